// ===== hdl/sbs_pkg.sv =====
// Shared constants, types and state encodings for the symbol histogram scorer.
package sbs_pkg;

  // Configuration defaults for the top level
  localparam int unsigned SBS_NUM_BINS   = 257;
  localparam int unsigned SBS_COUNT_BITS = 24;

  // Fixed field widths of the channels
  localparam int unsigned SYM_W   = 16;
  localparam int unsigned REST_W  = 24;
  localparam int unsigned CNT_W   = 24;
  localparam int unsigned SCORE_W = 32;

  // Symbol codes
  localparam logic [SYM_W-1:0] NULL_CODE   = 16'hFFFF;
  localparam logic [SYM_W-1:0] PTR_RESET   = 16'hFFFE;
  localparam int unsigned      PTR_BIN_IDX = 256;

  // Score arithmetic in Q16
  localparam int unsigned LG_FRAC_BITS = 16;
  localparam int unsigned LG_STEPS     = 16;
  localparam int unsigned SCORE_BIAS   = 16 << LG_FRAC_BITS;

  // Top level sequencer
  typedef enum logic [2:0] {
    ST_RUN,
    ST_CHECK,
    ST_LGL,
    ST_LGN,
    ST_DIV,
    ST_OUT
  } sbs_state_e;

  // Log2 unit sequencer
  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQ
  } sbs_lg_state_e;

endpackage

// ===== hdl/sbs_if.sv =====
// Valid/ready channel interfaces for the symbol stream and the result stream.
interface sbs_sym_if;
  logic                          valid;
  logic                          ready;
  logic [sbs_pkg::SYM_W-1:0]     symbol;
  logic [sbs_pkg::REST_W-1:0]    rest_count;
  logic                          last;

  modport source (output valid, symbol, rest_count, last, input ready);
  modport sink   (input valid, symbol, rest_count, last, output ready);
endinterface

interface sbs_res_if;
  logic                              valid;
  logic                              ready;
  logic [sbs_pkg::SYM_W-1:0]         best_symbol;
  logic [sbs_pkg::CNT_W-1:0]         best_count;
  logic signed [sbs_pkg::SCORE_W-1:0] score;
  logic                              score_invalid;
  logic [sbs_pkg::CNT_W-1:0]         bad_symbol_count;

  modport source (output valid, best_symbol, best_count, score, score_invalid,
                  bad_symbol_count, input ready);
  modport sink   (input valid, best_symbol, best_count, score, score_invalid,
                  bad_symbol_count, output ready);
endinterface

// ===== hdl/sbs_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module sbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sbs_lg.sv =====
// Iterative log2 unit: leading-one search one bit a cycle, then 16 squaring steps.
module sbs_lg #(
  parameter int unsigned W = sbs_pkg::SBS_COUNT_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] x_i,
  output logic         done_o,
  output logic [31:0]  res_o
);

  localparam int unsigned EW = $clog2(W);
  localparam int unsigned KW = $clog2(sbs_pkg::LG_STEPS);

  sbs_pkg::sbs_lg_state_e st_q, st_d;
  logic [W-1:0]                      xn_q, xn_d;
  logic [EW-1:0]                     e_q, e_d;
  logic [31:0]                       m_q, m_d;
  logic [sbs_pkg::LG_FRAC_BITS-1:0]  frac_q, frac_d;
  logic [KW-1:0]                     k_q, k_d;
  logic                              done_q, done_d;
  logic [63:0]                       prod;
  logic [32:0]                       sh;

  // Square of the Q1.31 mantissa, scaled back by 31
  assign prod = 64'(m_q) * 64'(m_q);
  assign sh   = prod[63:31];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= sbs_pkg::LG_IDLE;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xn_q   <= xn_d;
    e_q    <= e_d;
    m_q    <= m_d;
    frac_q <= frac_d;
  end

  // Next state: normalize, then extract fraction bits
  always_comb begin
    st_d   = st_q;
    xn_d   = xn_q;
    e_d    = e_q;
    m_d    = m_q;
    frac_d = frac_q;
    k_d    = k_q;
    done_d = 1'b0;
    case (st_q)
      sbs_pkg::LG_IDLE: begin
        if (start_i) begin
          xn_d   = x_i;
          e_d    = EW'(W - 1);
          frac_d = '0;
          st_d   = sbs_pkg::LG_NORM;
        end
      end
      sbs_pkg::LG_NORM: begin
        if (xn_q[W-1]) begin
          m_d  = 32'(xn_q) << (32 - W);
          k_d  = '0;
          st_d = sbs_pkg::LG_SQ;
        end else begin
          xn_d = xn_q << 1;
          e_d  = e_q - 1'b1;
        end
      end
      sbs_pkg::LG_SQ: begin
        if (sh[32]) begin
          m_d = sh[32:1];
        end else begin
          m_d = sh[31:0];
        end
        frac_d = {frac_q[sbs_pkg::LG_FRAC_BITS-2:0], sh[32]};
        k_d    = k_q + 1'b1;
        if (k_q == KW'(sbs_pkg::LG_STEPS - 1)) begin
          done_d = 1'b1;
          st_d   = sbs_pkg::LG_IDLE;
        end
      end
      default: begin
        st_d = sbs_pkg::LG_IDLE;
      end
    endcase
  end

  assign done_o = done_q;
  assign res_o  = 32'({e_q, frac_q});

endmodule

// ===== hdl/sbs_div.sv =====
// Restoring signed divider, one quotient bit a cycle, truncating toward zero.
module sbs_div #(
  parameter int unsigned VW = sbs_pkg::SBS_COUNT_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic [VW-1:0]      den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);

  logic          busy_q, done_q;
  logic [4:0]    cnt_q;
  logic [31:0]   a_q, q_q;
  logic [VW-1:0] rem_q, den_q;
  logic          neg_q;
  logic [VW:0]   trial;
  logic          ge;
  logic [31:0]   q_next;

  // One restoring step
  assign trial  = {rem_q, a_q[31]};
  assign ge     = trial >= {1'b0, den_q};
  assign q_next = {q_q[30:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and quotient path
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      a_q   <= num_i[31] ? 32'(-num_i) : 32'(num_i);
      neg_q <= num_i[31];
      den_q <= den_i;
      rem_q <= '0;
      q_q   <= '0;
    end else if (busy_q) begin
      a_q   <= a_q << 1;
      rem_q <= ge ? VW'(trial - {1'b0, den_q}) : VW'(trial);
      q_q   <= q_next;
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(q_q) : $signed(q_q);

endmodule

// ===== hdl/symbol_histogram_best_score.sv =====
// Top level: symbol histogram in RAM, best-bin tracking and final score sequencer.
//
//  channel | dir | handshake          | payload
//  sym_i   | in  | valid/ready        | symbol, rest_count, last
//  res_o   | out | valid/ready        | best_symbol, best_count, score,
//          |     |                    | score_invalid, bad_symbol_count
//  cfg     | in  | cfg_we_i           | cfg_data_i (pointer_symbol_code)
//
// One symbol a cycle: the bin is read at accept and written back the next
// cycle, with a forward of the previous write when the same bin repeats.
// After the last symbol, scoring uses the shared log2 unit twice and then
// the divider (neither for an invalid score); input is held off until the
// result sits in the output register. Reset clears all counts at once
// through per-bin valid bits; no clearing pass. A stalled result does not
// block input except while a newer result waits to be loaded.
module symbol_histogram_best_score #(
  parameter int unsigned NUM_BINS   = sbs_pkg::SBS_NUM_BINS,
  parameter int unsigned COUNT_BITS = sbs_pkg::SBS_COUNT_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  sbs_sym_if.sink                   sym_i,
  sbs_res_if.source                 res_o,
  input  logic                      cfg_we_i,
  input  logic [sbs_pkg::SYM_W-1:0] cfg_data_i
);

  localparam int unsigned BW = $clog2(NUM_BINS);
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  sbs_pkg::sbs_state_e state_q, state_d;

  logic [sbs_pkg::SYM_W-1:0]  ptr_q;
  logic                       acc;
  logic                       is_null, is_ptr, in_range;
  logic [BW-1:0]              bin_idx;

  // Stage 1 (read issued)
  logic                        s1_valid_q, s1_cnt_q, s1_err_q, s1_last_q;
  logic [BW-1:0]               s1_bin_q;
  logic [sbs_pkg::REST_W-1:0]  s1_rest_q;

  // Histogram state
  logic [NUM_BINS-1:0]   vld_q;
  logic                  fwd_valid_q;
  logic [BW-1:0]         fwd_bin_q;
  logic [COUNT_BITS-1:0] fwd_data_q;
  logic [COUNT_BITS-1:0] ram_rdata, old_cnt, new_cnt;
  logic                  we;
  logic [COUNT_BITS-1:0] top_count_q, len_q, err_q;
  logic [sbs_pkg::SYM_W-1:0] top_sym_q;
  logic                  clr;

  // Scoring
  logic                  invalid;
  logic                  lg_start, lg_done;
  logic [COUNT_BITS-1:0] lg_x;
  logic [31:0]           lg_res;
  logic signed [31:0]    lgl_q, lgl_d, lr_q, lr_d, num;
  logic                  div_start, div_done;
  logic signed [31:0]    div_quo;
  logic signed [32:0]    sum;
  logic signed [31:0]    score_q, score_d;
  logic                  inv_q, inv_d;

  // Output register
  logic                       res_valid_q;
  logic [sbs_pkg::SYM_W-1:0]  res_sym_q;
  logic [sbs_pkg::CNT_W-1:0]  res_cnt_q, res_bad_q;
  logic signed [31:0]         res_score_q;
  logic                       res_inv_q;
  logic                       load;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= sbs_pkg::PTR_RESET;
    end else if (cfg_we_i) begin
      ptr_q <= cfg_data_i;
    end
  end

  // Decode the incoming symbol
  assign sym_i.ready = (state_q == sbs_pkg::ST_RUN) && !(s1_valid_q && s1_last_q);
  assign acc         = sym_i.valid && sym_i.ready;
  assign is_null     = sym_i.symbol == sbs_pkg::NULL_CODE;
  assign is_ptr      = sym_i.symbol == ptr_q;
  assign in_range    = sym_i.symbol <= sbs_pkg::SYM_W'(sbs_pkg::PTR_BIN_IDX);
  assign bin_idx     = is_ptr ? BW'(sbs_pkg::PTR_BIN_IDX) : BW'(sym_i.symbol);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_cnt_q  <= !is_null && (is_ptr || in_range);
      s1_err_q  <= !is_null && !is_ptr && !in_range;
      s1_last_q <= sym_i.last;
      s1_bin_q  <= bin_idx;
      s1_rest_q <= sym_i.rest_count;
    end
  end

  sbs_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (s1_bin_q),
    .wdata_i (new_cnt),
    .re_i    (acc),
    .raddr_i (bin_idx),
    .rdata_o (ram_rdata)
  );

  // Modify: forward last cycle's write, treat unwritten bins as zero
  always_comb begin
    if (!vld_q[s1_bin_q]) begin
      old_cnt = '0;
    end else if (fwd_valid_q && (fwd_bin_q == s1_bin_q)) begin
      old_cnt = fwd_data_q;
    end else begin
      old_cnt = ram_rdata;
    end
    new_cnt = (old_cnt == CMAX) ? old_cnt : old_cnt + 1'b1;
  end

  assign we = s1_valid_q && s1_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      fwd_valid_q <= 1'b0;
      top_count_q <= '0;
      top_sym_q   <= '0;
      len_q       <= '0;
      err_q       <= '0;
    end else if (clr) begin
      vld_q       <= '0;
      fwd_valid_q <= 1'b0;
      top_count_q <= '0;
      top_sym_q   <= '0;
      len_q       <= '0;
      err_q       <= '0;
    end else begin
      fwd_valid_q <= we;
      if (s1_valid_q) begin
        if (len_q != CMAX) begin
          len_q <= len_q + 1'b1;
        end
        if (s1_err_q && (err_q != CMAX)) begin
          err_q <= err_q + 1'b1;
        end
      end
      if (we) begin
        vld_q[s1_bin_q] <= 1'b1;
        if (new_cnt > top_count_q) begin
          top_count_q <= new_cnt;
          top_sym_q   <= (s1_bin_q == BW'(sbs_pkg::PTR_BIN_IDX)) ? ptr_q
                                                                 : sbs_pkg::SYM_W'(s1_bin_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_bin_q  <= s1_bin_q;
    fwd_data_q <= new_cnt;
  end

  sbs_lg #(
    .W (COUNT_BITS)
  ) u_lg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lg_start),
    .x_i     (lg_x),
    .done_o  (lg_done),
    .res_o   (lg_res)
  );

  sbs_div #(
    .VW (COUNT_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (top_count_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign invalid = (top_count_q == '0) || (32'(s1_rest_q) >= 32'(len_q));
  assign num     = $signed(32'(sbs_pkg::SCORE_BIAS)) + lgl_q - $signed(lg_res);
  assign sum     = {div_quo[31], div_quo} + {lr_q[31], lr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbs_pkg::ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lgl_q   <= lgl_d;
    lr_q    <= lr_d;
    score_q <= score_d;
    inv_q   <= inv_d;
  end

  // Score sequencer
  always_comb begin
    state_d   = state_q;
    lg_start  = 1'b0;
    lg_x      = top_count_q;
    div_start = 1'b0;
    lgl_d     = lgl_q;
    lr_d      = lr_q;
    score_d   = score_q;
    inv_d     = inv_q;
    load      = 1'b0;
    clr       = 1'b0;
    case (state_q)
      sbs_pkg::ST_RUN: begin
        if (s1_valid_q && s1_last_q) begin
          state_d = sbs_pkg::ST_CHECK;
        end
      end
      sbs_pkg::ST_CHECK: begin
        if (invalid) begin
          score_d = '0;
          inv_d   = 1'b1;
          state_d = sbs_pkg::ST_OUT;
        end else begin
          lg_start = 1'b1;
          lg_x     = len_q - COUNT_BITS'(s1_rest_q);
          inv_d    = 1'b0;
          state_d  = sbs_pkg::ST_LGL;
        end
      end
      sbs_pkg::ST_LGL: begin
        if (lg_done) begin
          lgl_d    = $signed(lg_res);
          lg_start = 1'b1;
          state_d  = sbs_pkg::ST_LGN;
        end
      end
      sbs_pkg::ST_LGN: begin
        if (lg_done) begin
          lr_d      = lgl_q - $signed(lg_res);
          div_start = 1'b1;
          state_d   = sbs_pkg::ST_DIV;
        end
      end
      sbs_pkg::ST_DIV: begin
        if (div_done) begin
          if (sum[32] != sum[31]) begin
            score_d = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          end else begin
            score_d = sum[31:0];
          end
          state_d = sbs_pkg::ST_OUT;
        end
      end
      sbs_pkg::ST_OUT: begin
        if (!res_valid_q || res_o.ready) begin
          load    = 1'b1;
          clr     = 1'b1;
          state_d = sbs_pkg::ST_RUN;
        end
      end
      default: begin
        state_d = sbs_pkg::ST_RUN;
      end
    endcase
  end

  // Output register: hold until transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_sym_q   <= top_sym_q;
      res_cnt_q   <= sbs_pkg::CNT_W'(top_count_q);
      res_score_q <= score_q;
      res_inv_q   <= inv_q;
      res_bad_q   <= sbs_pkg::CNT_W'(err_q);
    end
  end

  assign res_o.valid            = res_valid_q;
  assign res_o.best_symbol      = res_sym_q;
  assign res_o.best_count       = res_cnt_q;
  assign res_o.score            = res_score_q;
  assign res_o.score_invalid    = res_inv_q;
  assign res_o.bad_symbol_count = res_bad_q;

  // No symbol enters behind a pending last symbol
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q) |=> !s1_valid_q)
    else $error("symbol accepted behind last symbol");

  // A new result comes only from the output state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q == sbs_pkg::ST_OUT))
    else $error("result loaded outside output state");

  // An invalid score is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_inv_q) |-> (res_score_q == '0))
    else $error("invalid score not zero");

  // The best count never drops while counting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbs_pkg::ST_RUN && $past(state_q == sbs_pkg::ST_RUN))
      |-> (top_count_q >= $past(top_count_q)))
    else $error("best count decreased");

  // Log2 results arrive only while the sequencer waits for them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lg_done |-> (state_q == sbs_pkg::ST_LGL || state_q == sbs_pkg::ST_LGN))
    else $error("stray log2 completion");

endmodule
